/* hdl/fdsc_pkg.sv */
// ----------------------------------------------------------------------------
// fdsc_pkg: shared types and constants of the frame deframer
// Status codes, register indexes and the result record that travels from the
// frame parser to the output buffering of the top level.
// ----------------------------------------------------------------------------
package fdsc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [POS_W-1:0] POS_MAX        = 9'd511;
  localparam logic [POS_W:0]   FRAME_OVERHEAD = 10'd7;
  localparam logic [POS_W-1:0] PAYLOAD_START  = 9'd3;
  localparam logic [POS_W-1:0] POS_HEADER_0   = 9'd0;
  localparam logic [POS_W-1:0] POS_HEADER_1   = 9'd1;
  localparam logic [POS_W-1:0] POS_LENGTH     = 9'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_HEADER   = 3'd2,
    ST_TAIL     = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_TAIL_FIRST    = 3'd2,
    CFG_TAIL_SECOND   = 3'd3,
    CFG_MAX_LEN       = 3'd4
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd170;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd85;
  localparam logic [BYTE_W-1:0] RST_TAIL_FIRST    = 8'd85;
  localparam logic [BYTE_W-1:0] RST_TAIL_SECOND   = 8'd170;
  localparam logic [BYTE_W-1:0] RST_MAX_LEN       = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] tail_first;
    logic [BYTE_W-1:0] tail_second;
    logic [BYTE_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_done;
    status_e           status;
    logic [BYTE_W-1:0] payload_length;
  } result_t;

endpackage

/* hdl/fdsc_parse.sv */
// ----------------------------------------------------------------------------
// fdsc_parse: per-frame parsing state and result generation
// Tracks position, header match, length, running checksum and the trailing
// bytes of a frame, and forms the result for the byte being presented.
// ----------------------------------------------------------------------------
module fdsc_parse
  import fdsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  output result_t           res_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              hdr_q, hdr_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  rx_sum_q, rx_sum_d;
  logic [BYTE_W-1:0] prev_q, prev_d;

  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_eac;
  logic [POS_W:0]    total;
  logic [POS_W:0]    pay_end;
  logic              pay;
  status_e           status;

  always_comb begin
    hdr_d = hdr_q;
    if (pos_q == POS_HEADER_0 && byte_i != cfg_i.header_first) begin
      hdr_d = 1'b0;
    end
    if (pos_q == POS_HEADER_1 && byte_i != cfg_i.header_second) begin
      hdr_d = 1'b0;
    end
    len_d = (pos_q == POS_LENGTH) ? byte_i : len_q;

    pay_end = {1'b0, PAYLOAD_START} + {{(POS_W + 1 - BYTE_W){1'b0}}, len_d};
    pay     = (pos_q >= PAYLOAD_START) && ({1'b0, pos_q} < pay_end);

    // One's complement style add: a carry out wraps around into bit zero.
    sum_raw = {1'b0, sum_q} + {{(SUM_W + 1 - BYTE_W){1'b0}}, byte_i};
    sum_eac = sum_raw[SUM_W] ? (sum_raw[SUM_W-1:0] + 1'b1) : sum_raw[SUM_W-1:0];
    sum_d   = pay ? sum_eac : sum_q;

    rx_sum_d = {rx_sum_q[BYTE_W-1:0], prev_q};
    prev_d   = byte_i;
    pos_d    = (pos_q < POS_MAX) ? (pos_q + 1'b1) : pos_q;

    total = {1'b0, pos_q} + 1'b1;
    if (total < FRAME_OVERHEAD) begin
      status = ST_LENGTH;
    end else if (!hdr_d) begin
      status = ST_HEADER;
    end else if (prev_q != cfg_i.tail_first || byte_i != cfg_i.tail_second) begin
      status = ST_TAIL;
    end else if (len_d > cfg_i.max_len) begin
      status = ST_LENGTH;
    end else if (total != FRAME_OVERHEAD + {{(POS_W + 1 - BYTE_W){1'b0}}, len_d}) begin
      status = ST_LENGTH;
    end else if (rx_sum_q != ~sum_d) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end

    res_o.payload_valid  = pay;
    res_o.payload_byte   = pay ? byte_i : '0;
    res_o.frame_done     = last_i;
    res_o.status         = last_i ? status : ST_OK;
    res_o.payload_length = last_i ? len_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= 1'b1;
      len_q    <= '0;
      sum_q    <= '0;
      rx_sum_q <= '0;
      prev_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q    <= '0;
        hdr_q    <= 1'b1;
        len_q    <= '0;
        sum_q    <= '0;
        rx_sum_q <= '0;
        prev_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        hdr_q    <= hdr_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
        rx_sum_q <= rx_sum_d;
        prev_q   <= prev_d;
      end
    end
  end

endmodule

/* hdl/frame_deframer_sum16_check.sv */
// ----------------------------------------------------------------------------
// frame_deframer_sum16_check: header/length/payload/checksum/tail deframer
// Streams frame bytes in, passes payload bytes out and reports one status on
// the last byte of every frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per transaction on the slave stream, with
// tlast on the final byte, and returns exactly one result transaction for each
// byte, registered, when the master side is ready. A frame is two header
// bytes, a length byte L, L payload bytes, a big-endian 16-bit checksum (the
// inverted end-around-carry sum of the payload bytes) and two tail bytes.
// Payload bytes are flagged by tuser as they pass; on the last byte tlast is
// set and tdata carries the status and the received length byte. If the
// status is not OK, downstream should drop the payload bytes of that frame.
// Throughput is one byte per clock while the skid is empty: the parse logic
// between the slave stream and the result register is a single compare-and-add
// stage, and a one-entry skid buffer keeps s_axis_tready high while one result
// waits on the master side. The five match and limit registers are written
// through the cfg port and should only be changed while no frame is in flight.
// ----------------------------------------------------------------------------
module frame_deframer_sum16_check
  import fdsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [BYTE_W-1:0]     cfg_wdata_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] byte_in
  input  logic                  s_axis_tlast,   // end_of_frame

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                                // [18:11] payload_length, [23:19] zero
  output logic                  m_axis_tuser,   // payload_valid
  output logic                  m_axis_tlast    // frame_done
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  logic    accept;
  logic    out_free;
  logic    load_out_new;
  logic    load_out_skid;
  logic    load_skid;

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= RST_HEADER_FIRST;
      cfg_q.header_second <= RST_HEADER_SECOND;
      cfg_q.tail_first    <= RST_TAIL_FIRST;
      cfg_q.tail_second   <= RST_TAIL_SECOND;
      cfg_q.max_len       <= RST_MAX_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata_i;
        CFG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata_i;
        CFG_TAIL_FIRST:    cfg_q.tail_first    <= cfg_wdata_i;
        CFG_TAIL_SECOND:   cfg_q.tail_second   <= cfg_wdata_i;
        CFG_MAX_LEN:       cfg_q.max_len       <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The slave side stalls only when the skid entry is occupied.
  assign s_axis_tready = !skid_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  fdsc_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .res_o    (res)
  );

  // Output register plus skid entry. The skid entry is older than any new
  // byte, so it always drains into the output register first.
  always_comb begin
    out_vld_d     = out_vld_q;
    skid_vld_d    = skid_vld_q;
    load_out_new  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (out_free) begin
      if (skid_vld_q) begin
        load_out_skid = 1'b1;
        out_vld_d     = 1'b1;
        skid_vld_d    = 1'b0;
      end else if (accept) begin
        load_out_new = 1'b1;
        out_vld_d    = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (accept) begin
      load_skid  = 1'b1;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_q <= skid_q;
    end else if (load_out_new) begin
      out_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2 * BYTE_W - 3){1'b0}}, out_q.payload_length,
                          out_q.status, out_q.payload_byte};
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tlast  = out_q.frame_done;

endmodule

/* hdl/fdsc_checker.sv */
// ----------------------------------------------------------------------------
// fdsc_checker: port-level checks of the frame deframer
// Watches the stream ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
module fdsc_checker
  import fdsc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result must stay valid and hold its data and last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Status and length are only reported on the last byte of a frame.
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[18:8] == 11'd0)
    else $error("status or length outside frame end");

  // Non-payload results carry a zero byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("data byte on a non-payload result");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:8] <= 3'd4)
    else $error("undefined status code");

  // With no pending result the skid entry must be empty, so input is open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind frame_deframer_sum16_check fdsc_checker u_fdsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
